>>> rtl/terminal_bus_decode_and_io_defines.svh
// assertion macros for the terminal bus slave
`ifndef TERMINAL_BUS_DECODE_AND_IO_DEFINES_SVH
`define TERMINAL_BUS_DECODE_AND_IO_DEFINES_SVH
`ifndef SYNTH
`define TBDIO_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tbdio assertion failed");
`define TBDIO_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbdio assertion failed");
`else
`define TBDIO_ASSERT(name, clk, rst_n, prop)
`define TBDIO_ASSERT_IMP(name, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/tbdio_pkg.sv
// types and constants of the terminal bus slave
package tbdio_pkg;

    typedef enum logic [2:0] {
        CMD_READ      = 3'd0,
        CMD_WRITE     = 3'd1,
        CMD_KEY       = 3'd2,
        CMD_RX        = 3'd3,
        CMD_TX_DRAIN  = 3'd4,
        CMD_MOUSE     = 3'd5,
        CMD_VBLANK    = 3'd6,
        CMD_ROM_LOAD  = 3'd7
    } cmd_t;

    typedef enum logic [3:0] {
        CL_NONE,
        CL_RAM,
        CL_ROM,
        CL_MOUSE_Y,
        CL_MOUSE_X,
        CL_SER_STAT,
        CL_SER_DATA,
        CL_BUTTONS,
        CL_DBASE,
        CL_DSTAT,
        CL_KEY_STAT,
        CL_KEY_DATA,
        CL_VBL_ACK
    } class_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    localparam int RAM_IDX_W   = 17;
    localparam int ROM_IDX_W   = 14;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    localparam logic [21:0] IO_BASE      = 22'h040000;
    localparam logic [21:0] ADDR_MOUSE_Y = 22'h060000;
    localparam logic [21:0] ADDR_MOUSE_X = 22'h060002;
    localparam logic [21:0] ADDR_SER_ST  = 22'h060008;
    localparam logic [21:0] ADDR_SER_DAT = 22'h06000A;
    localparam logic [21:0] ADDR_BTN_A   = 22'h060010;
    localparam logic [21:0] ADDR_BTN_B   = 22'h060014;
    localparam logic [21:0] ADDR_DBASE   = 22'h060018;
    localparam logic [21:0] ADDR_DSTAT   = 22'h060020;
    localparam logic [21:0] ADDR_KEY_ST  = 22'h060030;
    localparam logic [21:0] ADDR_KEY_DAT = 22'h060032;
    localparam logic [21:0] ADDR_VBL_ACK = 22'h060038;

    localparam int IRQ_VBL    = 0;
    localparam int IRQ_KEY    = 1;
    localparam int IRQ_MOUSE  = 2;
    localparam int IRQ_SERIAL = 3;

    localparam logic [7:0] CTL_TX_MASK = 8'h60;
    localparam logic [7:0] CTL_TX_IRQ  = 8'h20;
    localparam logic [7:0] CTL_RX_IRQ  = 8'h80;

    typedef struct packed {
        logic [2:0]  command;
        logic [21:0] address;
        logic [15:0] write_data;
        logic [15:0] write_mask;
        logic [7:0]  event_byte;
        logic [9:0]  mouse_x;
        logic [9:0]  mouse_y;
        logic [2:0]  mouse_buttons;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [3:0]  irq_lines;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [17:0] display_start;
        logic        display_invert;
    } res_item_t;

    typedef struct packed {
        cmd_t                   command;
        class_t                 cls;
        logic [RAM_IDX_W-1:0]   ram_idx;
        logic [ROM_IDX_W-1:0]   rom_idx;
        logic [15:0]            write_data;
        logic [15:0]            write_mask;
        logic [7:0]             event_byte;
        logic [9:0]             mouse_x;
        logic [9:0]             mouse_y;
        logic [2:0]             mouse_buttons;
    } work_item_t;

endpackage

>>> rtl/tbdio_ram.sv
// generic single-port ram with registered read
module tbdio_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tbdio_front.sv
// front end: accepts items, decodes addresses, reduces the ram index
module tbdio_front #(
    parameter int RAM_WORDS = 131072,
    parameter int ROM_WORDS = 12288
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  tbdio_pkg::in_item_t   cmd_item,
    output logic                  cmd_stall,
    output logic                  push,
    output tbdio_pkg::work_item_t push_item,
    input  logic                  q_full
);

    localparam logic [24:0] RECIP   = 25'((64'd1 << 34) / RAM_WORDS);
    localparam logic [21:0] ROM_END = 22'(64'h40000 + 2 * ROM_WORDS);

    logic                  st_valid_reg, st_valid_next;
    tbdio_pkg::work_item_t st_item_reg;
    logic [16:0]           st_idx_reg;
    logic [7:0]            st_q_reg;

    tbdio_pkg::class_t     cls;
    logic [13:0]           rom_idx;
    logic [21:0]           a;
    logic [21:0]           word_addr;
    logic [21:0]           rom_off;
    logic [16:0]           idx;
    logic [41:0]           prod;
    logic [25:0]           qn;
    logic [17:0]           rem;
    logic                  load;

    assign a         = cmd_item.address;
    assign word_addr = {a[21:1], 1'b0};
    assign rom_off   = a - tbdio_pkg::IO_BASE;
    assign idx       = a[17:1];
    assign prod      = 42'(idx) * 42'(RECIP);

    always_comb
    begin
        cls     = tbdio_pkg::CL_NONE;
        rom_idx = '0;
        if (tbdio_pkg::cmd_t'(cmd_item.command) == tbdio_pkg::CMD_ROM_LOAD)
        begin
            if (a < 22'(ROM_WORDS))
            begin
                cls     = tbdio_pkg::CL_ROM;
                rom_idx = a[13:0];
            end
        end
        else if (tbdio_pkg::cmd_t'(cmd_item.command) == tbdio_pkg::CMD_READ && a < 22'd8)
        begin
            cls     = tbdio_pkg::CL_ROM;
            rom_idx = 14'(a[2:1]);
        end
        else if (a < tbdio_pkg::IO_BASE)
        begin
            cls = tbdio_pkg::CL_RAM;
        end
        else if (a < ROM_END)
        begin
            cls     = tbdio_pkg::CL_ROM;
            rom_idx = rom_off[14:1];
        end
        else
        begin
            unique case (word_addr)
                tbdio_pkg::ADDR_MOUSE_Y: cls = tbdio_pkg::CL_MOUSE_Y;
                tbdio_pkg::ADDR_MOUSE_X: cls = tbdio_pkg::CL_MOUSE_X;
                tbdio_pkg::ADDR_SER_ST:  cls = tbdio_pkg::CL_SER_STAT;
                tbdio_pkg::ADDR_SER_DAT: cls = tbdio_pkg::CL_SER_DATA;
                tbdio_pkg::ADDR_BTN_A:   cls = tbdio_pkg::CL_BUTTONS;
                tbdio_pkg::ADDR_BTN_B:   cls = tbdio_pkg::CL_BUTTONS;
                tbdio_pkg::ADDR_DBASE:   cls = tbdio_pkg::CL_DBASE;
                tbdio_pkg::ADDR_DSTAT:   cls = tbdio_pkg::CL_DSTAT;
                tbdio_pkg::ADDR_KEY_ST:  cls = tbdio_pkg::CL_KEY_STAT;
                tbdio_pkg::ADDR_KEY_DAT: cls = tbdio_pkg::CL_KEY_DATA;
                tbdio_pkg::ADDR_VBL_ACK: cls = tbdio_pkg::CL_VBL_ACK;
                default:                 cls = tbdio_pkg::CL_NONE;
            endcase
        end
    end

    assign cmd_stall = st_valid_reg & q_full;
    assign push      = st_valid_reg & ~q_full;
    assign load      = cmd_valid & ~cmd_stall;

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (load)
        begin
            st_valid_next = 1'b1;
        end
        else if (push)
        begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            st_item_reg.command       <= tbdio_pkg::cmd_t'(cmd_item.command);
            st_item_reg.cls           <= cls;
            st_item_reg.ram_idx       <= '0;
            st_item_reg.rom_idx       <= rom_idx;
            st_item_reg.write_data    <= cmd_item.write_data;
            st_item_reg.write_mask    <= cmd_item.write_mask;
            st_item_reg.event_byte    <= cmd_item.event_byte;
            st_item_reg.mouse_x       <= cmd_item.mouse_x;
            st_item_reg.mouse_y       <= cmd_item.mouse_y;
            st_item_reg.mouse_buttons <= cmd_item.mouse_buttons;
            st_idx_reg                <= idx;
            st_q_reg                  <= prod[41:34];
        end
    end

    // quotient estimate is low by at most one
    assign qn  = 26'(st_q_reg) * 26'(RAM_WORDS);
    assign rem = 18'(26'(st_idx_reg) - qn);

    always_comb
    begin
        push_item = st_item_reg;
        if (rem >= 18'(RAM_WORDS))
        begin
            push_item.ram_idx = 17'(rem - 18'(RAM_WORDS));
        end
        else
        begin
            push_item.ram_idx = 17'(rem);
        end
    end

endmodule

>>> rtl/tbdio_queue.sv
// short item queue between front and back end
module tbdio_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tbdio_pkg::work_item_t push_item,
    input  logic                  pop,
    output tbdio_pkg::work_item_t head_item,
    output logic                  full,
    output logic                  empty
);

    tbdio_pkg::work_item_t             entries_reg [tbdio_pkg::QUEUE_DEPTH];
    logic [tbdio_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tbdio_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tbdio_pkg::QUEUE_CW-1:0]    count_reg, count_next;

    assign full      = count_reg == tbdio_pkg::QUEUE_CW'(tbdio_pkg::QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign head_item = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/tbdio_back.sv
// back end: memories, i/o registers, interrupts and result register
module tbdio_back #(
    parameter int RAM_WORDS = 131072,
    parameter int ROM_WORDS = 12288
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tbdio_pkg::work_item_t head_item,
    input  logic                  q_empty,
    output logic                  pop,
    output logic                  rsp_valid,
    output tbdio_pkg::res_item_t  rsp_item,
    input  logic                  rsp_stall
);

    localparam int RAM_AW = $clog2(RAM_WORDS);
    localparam int ROM_AW = $clog2(ROM_WORDS);

    tbdio_pkg::back_state_t state_reg, state_next;
    tbdio_pkg::work_item_t  cur_reg, cur_next;
    logic                   out_valid_reg, out_valid_next;
    tbdio_pkg::res_item_t   out_reg, out_next;

    logic [3:0]  irq_reg, irq_next;
    logic        key_v_reg, key_v_next;
    logic        rx_v_reg, rx_v_next;
    logic        tx_v_reg, tx_v_next;
    logic [7:0]  key_byte_reg, key_byte_next;
    logic [7:0]  rx_byte_reg, rx_byte_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic [7:0]  key_ctl_reg, key_ctl_next;
    logic [7:0]  ser_ctl_reg, ser_ctl_next;
    logic [15:0] dbase_reg, dbase_next;
    logic [15:0] dstat_reg, dstat_next;
    logic [19:0] mouse_pos_reg, mouse_pos_next;
    logic [2:0]  buttons_reg, buttons_next;

    logic              ram_we, rom_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [ROM_AW-1:0] rom_addr;
    logic [15:0]       ram_wdata, ram_rdata, rom_rdata;
    logic [15:0]       rd;
    logic [1:0]        stat;

    assign ram_addr  = (state_reg == tbdio_pkg::BK_EXEC) ? cur_reg.ram_idx[RAM_AW-1:0]
                                                        : head_item.ram_idx[RAM_AW-1:0];
    assign rom_addr  = (state_reg == tbdio_pkg::BK_EXEC) ? cur_reg.rom_idx[ROM_AW-1:0]
                                                        : head_item.rom_idx[ROM_AW-1:0];
    assign ram_wdata = (ram_rdata & ~cur_reg.write_mask) | (cur_reg.write_data & cur_reg.write_mask);

    tbdio_ram #(
        .WIDTH (16),
        .DEPTH (RAM_WORDS)
    ) u_main_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    tbdio_ram #(
        .WIDTH (16),
        .DEPTH (ROM_WORDS)
    ) u_boot_ram (
        .clk   (clk),
        .we    (rom_we),
        .addr  (rom_addr),
        .wdata (cur_reg.write_data),
        .rdata (rom_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg & rsp_stall;
        out_next       = out_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        rom_we         = 1'b0;
        rd             = '0;
        stat           = '0;
        irq_next       = irq_reg;
        key_v_next     = key_v_reg;
        rx_v_next      = rx_v_reg;
        tx_v_next      = tx_v_reg;
        key_byte_next  = key_byte_reg;
        rx_byte_next   = rx_byte_reg;
        tx_byte_next   = tx_byte_reg;
        key_ctl_next   = key_ctl_reg;
        ser_ctl_next   = ser_ctl_reg;
        dbase_next     = dbase_reg;
        dstat_next     = dstat_reg;
        mouse_pos_next = mouse_pos_reg;
        buttons_next   = buttons_reg;

        unique case (state_reg)
            tbdio_pkg::BK_IDLE:
            begin
                if (!q_empty && (!out_valid_reg || !rsp_stall))
                begin
                    pop        = 1'b1;
                    cur_next   = head_item;
                    state_next = tbdio_pkg::BK_EXEC;
                end
            end
            tbdio_pkg::BK_EXEC:
            begin
                unique case (cur_reg.command)
                    tbdio_pkg::CMD_READ:
                    begin
                        unique case (cur_reg.cls)
                            tbdio_pkg::CL_RAM:     rd = ram_rdata;
                            tbdio_pkg::CL_ROM:     rd = rom_rdata;
                            tbdio_pkg::CL_MOUSE_Y: rd = {6'd0, mouse_pos_reg[19:10]};
                            tbdio_pkg::CL_MOUSE_X: rd = {6'd0, mouse_pos_reg[9:0]};
                            tbdio_pkg::CL_SER_STAT:
                            begin
                                stat = {~tx_v_reg, rx_v_reg};
                                rd   = {6'd0, stat, 6'd0, stat};
                            end
                            tbdio_pkg::CL_SER_DATA:
                            begin
                                if (rx_v_reg)
                                begin
                                    rd        = {rx_byte_reg, rx_byte_reg};
                                    rx_v_next = 1'b0;
                                end
                                else
                                begin
                                    rd = 16'hFFFF;
                                end
                            end
                            tbdio_pkg::CL_BUTTONS:
                            begin
                                rd = {5'd0, buttons_reg, 5'd0, buttons_reg};
                                irq_next[tbdio_pkg::IRQ_MOUSE] = 1'b0;
                            end
                            tbdio_pkg::CL_DBASE:   rd = dbase_reg;
                            tbdio_pkg::CL_DSTAT:   rd = dstat_reg;
                            tbdio_pkg::CL_KEY_STAT:
                            begin
                                stat = {1'b1, key_v_reg};
                                rd   = {6'd0, stat, 6'd0, stat};
                            end
                            tbdio_pkg::CL_KEY_DATA:
                            begin
                                if (key_v_reg)
                                begin
                                    rd         = {key_byte_reg, key_byte_reg};
                                    key_v_next = 1'b0;
                                end
                                else
                                begin
                                    rd = 16'hFFFF;
                                end
                            end
                            default:               rd = '0;
                        endcase
                    end
                    tbdio_pkg::CMD_WRITE:
                    begin
                        unique case (cur_reg.cls)
                            tbdio_pkg::CL_RAM:      ram_we = 1'b1;
                            tbdio_pkg::CL_SER_STAT: ser_ctl_next = cur_reg.write_data[7:0];
                            tbdio_pkg::CL_SER_DATA:
                            begin
                                tx_byte_next = cur_reg.write_data[7:0];
                                tx_v_next    = 1'b1;
                            end
                            tbdio_pkg::CL_DBASE:
                                dbase_next = (dbase_reg & ~cur_reg.write_mask)
                                           | (cur_reg.write_data & cur_reg.write_mask);
                            tbdio_pkg::CL_DSTAT:
                                dstat_next = (dstat_reg & ~cur_reg.write_mask)
                                           | (cur_reg.write_data & cur_reg.write_mask);
                            tbdio_pkg::CL_KEY_STAT: key_ctl_next = cur_reg.write_data[7:0];
                            tbdio_pkg::CL_VBL_ACK:  irq_next[tbdio_pkg::IRQ_VBL] = 1'b0;
                            default:                ram_we = 1'b0;
                        endcase
                    end
                    tbdio_pkg::CMD_KEY:
                    begin
                        if (!key_v_reg)
                        begin
                            key_byte_next = cur_reg.event_byte;
                            key_v_next    = 1'b1;
                        end
                    end
                    tbdio_pkg::CMD_RX:
                    begin
                        if (!rx_v_reg)
                        begin
                            rx_byte_next = cur_reg.event_byte;
                            rx_v_next    = 1'b1;
                        end
                    end
                    tbdio_pkg::CMD_TX_DRAIN: tx_v_next = 1'b0;
                    tbdio_pkg::CMD_MOUSE:
                    begin
                        mouse_pos_next = {cur_reg.mouse_y, cur_reg.mouse_x};
                        buttons_next   = cur_reg.mouse_buttons;
                        irq_next[tbdio_pkg::IRQ_MOUSE] = 1'b1;
                    end
                    tbdio_pkg::CMD_VBLANK:   irq_next[tbdio_pkg::IRQ_VBL] = 1'b1;
                    tbdio_pkg::CMD_ROM_LOAD: rom_we = cur_reg.cls == tbdio_pkg::CL_ROM;
                    default:                 rd = '0;
                endcase

                irq_next[tbdio_pkg::IRQ_KEY] = key_v_next
                                             & (|(key_ctl_next & tbdio_pkg::CTL_RX_IRQ));
                irq_next[tbdio_pkg::IRQ_SERIAL] =
                    (rx_v_next & (|(ser_ctl_next & tbdio_pkg::CTL_RX_IRQ)))
                    | (~tx_v_next
                       & ((ser_ctl_next & tbdio_pkg::CTL_TX_MASK) == tbdio_pkg::CTL_TX_IRQ));

                out_next.read_data      = rd;
                out_next.irq_lines      = irq_next;
                out_next.tx_valid       = tx_v_next;
                out_next.tx_byte        = tx_v_next ? tx_byte_next : 8'd0;
                out_next.display_start  = {dbase_next, 2'b00};
                out_next.display_invert = dstat_next[0];
                out_valid_next          = 1'b1;
                state_next              = tbdio_pkg::BK_IDLE;
            end
            default: state_next = tbdio_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tbdio_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            irq_reg       <= '0;
            key_v_reg     <= 1'b0;
            rx_v_reg      <= 1'b0;
            tx_v_reg      <= 1'b0;
            key_byte_reg  <= '0;
            rx_byte_reg   <= '0;
            tx_byte_reg   <= '0;
            key_ctl_reg   <= '0;
            ser_ctl_reg   <= '0;
            dbase_reg     <= '0;
            dstat_reg     <= '0;
            mouse_pos_reg <= '0;
            buttons_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            irq_reg       <= irq_next;
            key_v_reg     <= key_v_next;
            rx_v_reg      <= rx_v_next;
            tx_v_reg      <= tx_v_next;
            key_byte_reg  <= key_byte_next;
            rx_byte_reg   <= rx_byte_next;
            tx_byte_reg   <= tx_byte_next;
            key_ctl_reg   <= key_ctl_next;
            ser_ctl_reg   <= ser_ctl_next;
            dbase_reg     <= dbase_next;
            dstat_reg     <= dstat_next;
            mouse_pos_reg <= mouse_pos_next;
            buttons_reg   <= buttons_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

endmodule

>>> rtl/terminal_bus_decode_and_io.sv
// top level of the terminal bus slave
// an item passes the front-end stage register, the queue and the back end's exec state before
// its result is registered; the back end takes one item at a time, idle then exec, as set by the
// read-modify-write pass through the single-port main and boot memories in the back end
// reset clears the i/o registers, interrupt lines, holding registers and queue;
// main and boot memory contents are not cleared and stay undefined until written
`include "terminal_bus_decode_and_io_defines.svh"
module terminal_bus_decode_and_io #(
    parameter int RAM_WORDS = 131072,
    parameter int ROM_WORDS = 12288
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  tbdio_pkg::in_item_t  cmd_item,
    output logic                 cmd_stall,
    output logic                 rsp_valid,
    output tbdio_pkg::res_item_t rsp_item,
    input  logic                 rsp_stall
);

    logic                  push, pop, q_full, q_empty;
    tbdio_pkg::work_item_t push_item, head_item;

    tbdio_front #(
        .RAM_WORDS (RAM_WORDS),
        .ROM_WORDS (ROM_WORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_item  (cmd_item),
        .cmd_stall (cmd_stall),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    tbdio_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    tbdio_back #(
        .RAM_WORDS (RAM_WORDS),
        .ROM_WORDS (ROM_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .q_empty   (q_empty),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_item  (rsp_item),
        .rsp_stall (rsp_stall)
    );

    `TBDIO_ASSERT(a_no_overflow, clk, rst_n, !(push && q_full))
    `TBDIO_ASSERT(a_no_underflow, clk, rst_n, !(pop && q_empty))
    `TBDIO_ASSERT_IMP(a_tx_empty_zero, clk, rst_n, rsp_valid && !rsp_item.tx_valid, rsp_item.tx_byte == 8'd0)

endmodule

>>> dv/tb_top.sv
// self-checking testbench of the terminal bus slave with a built-in predictor
`timescale 1ns / 100ps
module tb_top;

    localparam int RAM_N = 131072;
    localparam int ROM_N = 12288;
    localparam int N_RANDOM = 925;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [21:0] ROM_END = 22'(tbdio_pkg::IO_BASE + 2 * ROM_N);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    tbdio_pkg::in_item_t cmd_item = '0;
    logic cmd_stall;
    logic rsp_valid;
    tbdio_pkg::res_item_t rsp_item;
    logic rsp_stall = 1'b0;

    terminal_bus_decode_and_io #(.RAM_WORDS(RAM_N), .ROM_WORDS(ROM_N)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_item(cmd_item),
        .cmd_stall(cmd_stall),
        .rsp_valid(rsp_valid),
        .rsp_item(rsp_item),
        .rsp_stall(rsp_stall)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted terminal state
    logic [15:0] ram_words [int];
    logic [15:0] rom_words [int];
    logic [3:0] irq_pend;
    logic key_full, rx_full, tx_full;
    logic [7:0] key_byte, rx_byte, tx_byte;
    logic [7:0] kbd_ctl, ser_ctl;
    logic [15:0] dbase, dstat;
    logic [19:0] mouse_pos;
    logic [2:0] mouse_btn;

    tbdio_pkg::in_item_t pending_items [$];
    tbdio_pkg::res_item_t expected_results [$];
    int errors = 0;
    int cycles = 0;
    int results_seen = 0;

    // stimulus-side record of which memory words hold defined data
    bit ram_known [int];
    bit rom_known [int];
    int ram_list [$];
    int rom_list [$];

    task automatic report(input string field, input int got, input int want);
        $display("mismatch on %s: got %0h expected %0h", field, got, want);
        errors++;
    endtask

    function automatic logic [15:0] both_halves(input logic [7:0] b);
        return {b, b};
    endfunction

    function automatic tbdio_pkg::res_item_t predict_terminal(input tbdio_pkg::in_item_t it);
        tbdio_pkg::res_item_t r;
        logic [21:0] a;
        logic [21:0] aa;
        logic [15:0] rd;
        logic [7:0] st;
        int idx;
        r = '0;
        rd = '0;
        a = it.address;
        case (it.command)
            tbdio_pkg::CMD_READ:
            begin
                if (a < 8) a = a + tbdio_pkg::IO_BASE;
                aa = {a[21:1], 1'b0};
                if (a < tbdio_pkg::IO_BASE) rd = ram_words[int'(a >> 1)];
                else if (a < ROM_END) rd = rom_words[int'((a - tbdio_pkg::IO_BASE) >> 1)];
                else
                begin
                    case (aa)
                        tbdio_pkg::ADDR_MOUSE_Y: rd = {6'd0, mouse_pos[19:10]};
                        tbdio_pkg::ADDR_MOUSE_X: rd = {6'd0, mouse_pos[9:0]};
                        tbdio_pkg::ADDR_SER_ST:
                        begin
                            st = {6'd0, !tx_full, rx_full};
                            rd = both_halves(st);
                        end
                        tbdio_pkg::ADDR_SER_DAT:
                        begin
                            if (!rx_full) rd = 16'hFFFF;
                            else
                            begin
                                rx_full = 1'b0;
                                rd = both_halves(rx_byte);
                            end
                        end
                        tbdio_pkg::ADDR_BTN_A, tbdio_pkg::ADDR_BTN_B:
                        begin
                            irq_pend[tbdio_pkg::IRQ_MOUSE] = 1'b0;
                            rd = both_halves({5'd0, mouse_btn});
                        end
                        tbdio_pkg::ADDR_DBASE: rd = dbase;
                        tbdio_pkg::ADDR_DSTAT: rd = dstat;
                        tbdio_pkg::ADDR_KEY_ST: rd = both_halves({6'd0, 1'b1, key_full});
                        tbdio_pkg::ADDR_KEY_DAT:
                        begin
                            if (!key_full) rd = 16'hFFFF;
                            else
                            begin
                                key_full = 1'b0;
                                rd = both_halves(key_byte);
                            end
                        end
                        default: rd = '0;
                    endcase
                end
            end
            tbdio_pkg::CMD_WRITE:
            begin
                aa = {a[21:1], 1'b0};
                if (a < tbdio_pkg::IO_BASE)
                begin
                    idx = int'(a >> 1);
                    if (!ram_words.exists(idx)) ram_words[idx] = '0;
                    ram_words[idx] = (ram_words[idx] & ~it.write_mask)
                                     | (it.write_data & it.write_mask);
                end
                else
                begin
                    case (aa)
                        tbdio_pkg::ADDR_SER_ST: ser_ctl = it.write_data[7:0];
                        tbdio_pkg::ADDR_SER_DAT:
                        begin
                            tx_byte = it.write_data[7:0];
                            tx_full = 1'b1;
                        end
                        tbdio_pkg::ADDR_DBASE: dbase = (dbase & ~it.write_mask)
                                                       | (it.write_data & it.write_mask);
                        tbdio_pkg::ADDR_DSTAT: dstat = (dstat & ~it.write_mask)
                                                       | (it.write_data & it.write_mask);
                        tbdio_pkg::ADDR_KEY_ST: kbd_ctl = it.write_data[7:0];
                        tbdio_pkg::ADDR_VBL_ACK: irq_pend[tbdio_pkg::IRQ_VBL] = 1'b0;
                        default: ;
                    endcase
                end
            end
            tbdio_pkg::CMD_KEY:
            begin
                if (!key_full)
                begin
                    key_byte = it.event_byte;
                    key_full = 1'b1;
                end
            end
            tbdio_pkg::CMD_RX:
            begin
                if (!rx_full)
                begin
                    rx_byte = it.event_byte;
                    rx_full = 1'b1;
                end
            end
            tbdio_pkg::CMD_TX_DRAIN: tx_full = 1'b0;
            tbdio_pkg::CMD_MOUSE:
            begin
                mouse_pos = {it.mouse_y, it.mouse_x};
                mouse_btn = it.mouse_buttons;
                irq_pend[tbdio_pkg::IRQ_MOUSE] = 1'b1;
            end
            tbdio_pkg::CMD_VBLANK: irq_pend[tbdio_pkg::IRQ_VBL] = 1'b1;
            default:
            begin
                if (a < ROM_N) rom_words[int'(a)] = it.write_data;
            end
        endcase
        irq_pend[tbdio_pkg::IRQ_KEY] = key_full && (kbd_ctl & tbdio_pkg::CTL_RX_IRQ) != 0;
        irq_pend[tbdio_pkg::IRQ_SERIAL] =
            (rx_full && (ser_ctl & tbdio_pkg::CTL_RX_IRQ) != 0)
            || (!tx_full && (ser_ctl & tbdio_pkg::CTL_TX_MASK) == tbdio_pkg::CTL_TX_IRQ);
        r.read_data = rd;
        r.irq_lines = irq_pend;
        r.tx_valid = tx_full;
        r.tx_byte = tx_full ? tx_byte : 8'd0;
        r.display_start = {dbase, 2'b00};
        r.display_invert = dstat[0];
        return r;
    endfunction

    // queue an item, keeping track of which memory words become defined
    task automatic add_item(input tbdio_pkg::in_item_t it);
        int idx;
        if (it.command == tbdio_pkg::CMD_WRITE && it.address < tbdio_pkg::IO_BASE)
        begin
            idx = int'(it.address >> 1);
            if (!ram_known.exists(idx))
            begin
                it.write_mask = 16'hFFFF;
                ram_known[idx] = 1'b1;
                ram_list.push_back(idx);
            end
        end
        if (it.command == tbdio_pkg::CMD_ROM_LOAD && it.address < ROM_N
            && !rom_known.exists(int'(it.address)))
        begin
            rom_known[int'(it.address)] = 1'b1;
            rom_list.push_back(int'(it.address));
        end
        pending_items.push_back(it);
    endtask

    function automatic tbdio_pkg::in_item_t rand_fields(input tbdio_pkg::cmd_t c,
                                                        input logic [21:0] a);
        tbdio_pkg::in_item_t it;
        it.command = c;
        it.address = a;
        it.write_data = 16'($urandom);
        it.write_mask = 16'($urandom);
        it.event_byte = 8'($urandom);
        it.mouse_x = 10'($urandom);
        it.mouse_y = 10'($urandom);
        it.mouse_buttons = 3'($urandom);
        return it;
    endfunction

    function automatic logic [21:0] io_addr();
        logic [21:0] regs [12];
        regs = '{tbdio_pkg::ADDR_MOUSE_Y, tbdio_pkg::ADDR_MOUSE_X, tbdio_pkg::ADDR_SER_ST,
                 tbdio_pkg::ADDR_SER_DAT, tbdio_pkg::ADDR_BTN_A, tbdio_pkg::ADDR_BTN_B,
                 tbdio_pkg::ADDR_DBASE, tbdio_pkg::ADDR_DSTAT, tbdio_pkg::ADDR_KEY_ST,
                 tbdio_pkg::ADDR_KEY_DAT, tbdio_pkg::ADDR_VBL_ACK,
                 tbdio_pkg::ADDR_BTN_B + 22'd2};
        return regs[$urandom_range(0, 11)] | 22'($urandom_range(0, 1));
    endfunction

    function automatic logic [21:0] safe_read_addr();
        logic [21:0] a;
        case ($urandom_range(0, 5))
            0: a = 22'(ram_list[$urandom_range(0, ram_list.size() - 1)] * 2 + $urandom_range(0, 1));
            1: a = 22'(tbdio_pkg::IO_BASE + rom_list[$urandom_range(0, rom_list.size() - 1)] * 2
                       + $urandom_range(0, 1));
            2: a = 22'($urandom_range(0, 7));
            3:
            begin
                a = 22'($urandom);
                if (a < ROM_END) a = a | 22'h200000;
            end
            default: a = io_addr();
        endcase
        return a;
    endfunction

    function automatic logic [21:0] rand_write_addr();
        case ($urandom_range(0, 5))
            0: return 22'($urandom_range(0, 63));
            1: return 22'($urandom) & 22'h03FFFF;
            2: return 22'($urandom);
            default: return io_addr();
        endcase
    endfunction

    // driver: bursts of items with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd_item <= '0;
        end
        else if (!cmd_valid || !cmd_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                cmd_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                cmd_valid <= 1'b1;
                cmd_item <= pending_items.pop_front();
                if (burst_left > 0) burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else cmd_valid <= 1'b0;
        end
    end

    // receiver stall pattern, with one long hold-off
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) rsp_stall <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end
            else mode_left--;
            if (!hold_done && results_seen >= 300)
            begin
                hold_done = 1'b1;
                hold_left = 200;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (stall_mode == 1) rsp_stall <= ($urandom_range(0, 2) == 0);
            else if (stall_mode == 2) rsp_stall <= (cycles % 5 < 2);
            else rsp_stall <= 1'b0;
        end
    end

    // monitor: predict on accepted items, check accepted results
    tbdio_pkg::res_item_t want;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall) expected_results.push_back(predict_terminal(cmd_item));
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0) report("unexpected item", 0, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_item.read_data !== want.read_data)
                        report("read_data", rsp_item.read_data, want.read_data);
                    if (rsp_item.irq_lines !== want.irq_lines)
                        report("irq_lines", rsp_item.irq_lines, want.irq_lines);
                    if (rsp_item.tx_valid !== want.tx_valid)
                        report("tx_valid", rsp_item.tx_valid, want.tx_valid);
                    if (rsp_item.tx_byte !== want.tx_byte)
                        report("tx_byte", rsp_item.tx_byte, want.tx_byte);
                    if (rsp_item.display_start !== want.display_start)
                        report("display_start", rsp_item.display_start, want.display_start);
                    if (rsp_item.display_invert !== want.display_invert)
                        report("display_invert", rsp_item.display_invert, want.display_invert);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        tbdio_pkg::in_item_t it;
        int r;
        irq_pend = '0;
        key_full = 1'b0;
        rx_full = 1'b0;
        tx_full = 1'b0;
        key_byte = '0;
        rx_byte = '0;
        tx_byte = '0;
        kbd_ctl = '0;
        ser_ctl = '0;
        dbase = '0;
        dstat = '0;
        mouse_pos = '0;
        mouse_btn = '0;

        // directed part
        for (int i = 0; i < 4; i++) add_item(rand_fields(tbdio_pkg::CMD_ROM_LOAD, 22'(i)));
        add_item(rand_fields(tbdio_pkg::CMD_ROM_LOAD, 22'(ROM_N - 1)));
        add_item(rand_fields(tbdio_pkg::CMD_ROM_LOAD, 22'(ROM_N)));
        add_item(rand_fields(tbdio_pkg::CMD_ROM_LOAD, 22'h3FFFFF));
        add_item(rand_fields(tbdio_pkg::CMD_READ, 22'd7));
        add_item(rand_fields(tbdio_pkg::CMD_WRITE, 22'd2));
        add_item(rand_fields(tbdio_pkg::CMD_WRITE, 22'h03FFFF));
        add_item(rand_fields(tbdio_pkg::CMD_READ, 22'h03FFFE));
        add_item(rand_fields(tbdio_pkg::CMD_READ, tbdio_pkg::IO_BASE + 22'(2 * ROM_N - 1)));
        add_item(rand_fields(tbdio_pkg::CMD_READ, tbdio_pkg::ADDR_SER_DAT));
        add_item(rand_fields(tbdio_pkg::CMD_READ, tbdio_pkg::ADDR_KEY_DAT));
        it = rand_fields(tbdio_pkg::CMD_WRITE, tbdio_pkg::ADDR_KEY_ST);
        it.write_data = 16'h0080;
        add_item(it);
        add_item(rand_fields(tbdio_pkg::CMD_KEY, 22'd0));
        add_item(rand_fields(tbdio_pkg::CMD_KEY, 22'd0));
        add_item(rand_fields(tbdio_pkg::CMD_READ, tbdio_pkg::ADDR_KEY_DAT));
        it = rand_fields(tbdio_pkg::CMD_WRITE, tbdio_pkg::ADDR_SER_ST);
        it.write_data = 16'h00A0;
        add_item(it);
        add_item(rand_fields(tbdio_pkg::CMD_RX, 22'd0));
        add_item(rand_fields(tbdio_pkg::CMD_WRITE, tbdio_pkg::ADDR_SER_DAT));
        add_item(rand_fields(tbdio_pkg::CMD_TX_DRAIN, 22'd0));
        add_item(rand_fields(tbdio_pkg::CMD_MOUSE, 22'd0));
        add_item(rand_fields(tbdio_pkg::CMD_VBLANK, 22'd0));
        add_item(rand_fields(tbdio_pkg::CMD_READ, tbdio_pkg::ADDR_BTN_A));
        it = rand_fields(tbdio_pkg::CMD_WRITE, tbdio_pkg::ADDR_DBASE);
        it.write_data = 16'hFFFF;
        it.write_mask = 16'hFFFF;
        add_item(it);
        add_item(rand_fields(tbdio_pkg::CMD_WRITE, tbdio_pkg::ADDR_VBL_ACK));

        // random part
        for (int n = 0; n < N_RANDOM; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35) add_item(rand_fields(tbdio_pkg::CMD_READ, safe_read_addr()));
            else if (r < 65) add_item(rand_fields(tbdio_pkg::CMD_WRITE, rand_write_addr()));
            else if (r < 72) add_item(rand_fields(tbdio_pkg::CMD_KEY, 22'($urandom)));
            else if (r < 79) add_item(rand_fields(tbdio_pkg::CMD_RX, 22'($urandom)));
            else if (r < 84) add_item(rand_fields(tbdio_pkg::CMD_TX_DRAIN, 22'($urandom)));
            else if (r < 89) add_item(rand_fields(tbdio_pkg::CMD_MOUSE, 22'($urandom)));
            else if (r < 93) add_item(rand_fields(tbdio_pkg::CMD_VBLANK, 22'($urandom)));
            else if (r < 97)
                add_item(rand_fields(tbdio_pkg::CMD_ROM_LOAD, 22'($urandom_range(0, ROM_N + 50))));
            else add_item(rand_fields(tbdio_pkg::CMD_ROM_LOAD, 22'($urandom)));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_items.size() == 0 && !cmd_valid);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
